[rtl/core/scoped_binding_register_allocator_core_defines.svh]
// assertion macros for the scoped binding register allocator
// used by the top level only; expects signals named clock and reset in scope
`ifndef SCOPED_BINDING_REGISTER_ALLOCATOR_CORE_DEFINES_SVH
`define SCOPED_BINDING_REGISTER_ALLOCATOR_CORE_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define SAB_ASSERT_HOLDS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("sab invariant failed");

// consequent must hold in the same cycle as the antecedent
`define SAB_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sab implication failed");

`endif

[rtl/core/sab_pkg.sv]
// shared types and constants for the scoped binding register allocator
// no dependencies; imported by sab_front, sab_back and the top level
package sab_pkg;

   localparam int REQ_CODE_BITS = 3;
   localparam int REQ_KEY_BITS  = 16;
   localparam int RSP_REG_BITS  = 6;
   localparam int TEMP_BITS     = 16;

   // binding kinds as stored in the stack
   localparam logic KIND_VAR  = 1'b0;
   localparam logic KIND_TEMP = 1'b1;

   // request codes on the input channel
   typedef enum logic [REQ_CODE_BITS-1:0] {
      RQ_BIND_VAR    = 3'd0,
      RQ_BIND_TEMP   = 3'd1,
      RQ_UNBIND_VAR  = 3'd2,
      RQ_UNBIND_TEMP = 3'd3,
      RQ_LOOKUP      = 3'd4,
      RQ_HAS         = 3'd5,
      RQ_FRESH_TEMP  = 3'd6
   } req_code_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_EMPTY        = 3'd1,
      ST_WRONG_KIND   = 3'd2,
      ST_KEY_MISMATCH = 3'd3,
      ST_UNBOUND      = 3'd4,
      ST_FULL         = 3'd5
   } status_type;

   // classified operation handed from front to back
   typedef enum logic [2:0] {
      OP_NOP,
      OP_BIND,
      OP_UNBIND,
      OP_FIND,
      OP_FRESH
   } op_type;

   // back end sequencer states
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ALLOC,
      BK_POP_CHK,
      BK_FIND,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      logic [REQ_CODE_BITS-1:0] req_type;
      logic [REQ_KEY_BITS-1:0]  key;
   } req_beat_type;

   typedef struct packed {
      logic [RSP_REG_BITS-1:0] reg_index;
      logic                    found;
      logic [TEMP_BITS-1:0]    temp_number;
      status_type              status;
   } rsp_beat_type;

   typedef struct packed {
      op_type                  op;
      logic                    kind;
      logic                    miss_flag;
      logic [REQ_KEY_BITS-1:0] key;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   typedef struct packed {
      logic busy;
      logic stack_full;
   } back_stat_type;

endpackage

[rtl/core/scoped_binding_register_allocator_core.sv]
// Scoped binding register allocator. Requests are classified and held in a two-beat command
// queue, so the request side keeps flowing while the back end works; a result register lets
// the back end finish while the previous result still waits. The back end runs one command at
// a time. Fresh temp, unknown codes, bind on a full stack and unbind on an empty stack go
// straight to the done state; an unbind reads the top entry and checks it in the pop-check
// state; a bind walks the free-register search, which tests one index per cycle upward from
// register zero; lookup and has scan the bindings one entry per cycle from the top, as the
// binding memory has a single read port, and stop on a hit. No clearing pass is needed after reset.
// Depends on sab_pkg, sab_front, sab_back and the assertion macro header.
`include "scoped_binding_register_allocator_core_defines.svh"

module scoped_binding_register_allocator_core import sab_pkg::*; #(
   parameter int STACK_DEPTH = 32,
   parameter int KEY_BITS    = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_beat_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_beat_type rsp_data
);

   queue_head_type q_head;
   logic           q_pop;
   back_stat_type  bk_stat;

   // accept and classify
   sab_front #(
      .KEY_BITS (KEY_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_head    (q_head),
      .q_pop     (q_pop)
   );

   // execute against the binding stack
   sab_back #(
      .STACK_DEPTH (STACK_DEPTH),
      .KEY_BITS    (KEY_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .bk_stat   (bk_stat)
   );

   // checks
   `SAB_ASSERT_IMPLY(a_pop_needs_head, q_pop, q_head.valid)
   `SAB_ASSERT_IMPLY(a_pop_only_idle, q_pop, !bk_stat.busy)
   `SAB_ASSERT_IMPLY(a_found_is_ok, rsp_valid && rsp_data.found, rsp_data.status == ST_OK)
   `SAB_ASSERT_HOLDS(a_full_blocks_nothing, !(rsp_valid && rsp_data.status == ST_FULL && rsp_data.reg_index != '0))

endmodule

[rtl/core/sab_front.sv]
// front end: accepts request beats, classifies them and queues commands
// depends on sab_pkg
module sab_front import sab_pkg::*; #(
   parameter int KEY_BITS = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  req_beat_type   req_data,
   output queue_head_type q_head,
   input  logic           q_pop
);

   localparam int KW          = (KEY_BITS < REQ_KEY_BITS) ? KEY_BITS : REQ_KEY_BITS;
   localparam int QUEUE_DEPTH = 2;
   localparam int PW          = $clog2(QUEUE_DEPTH);
   localparam int FW          = $clog2(QUEUE_DEPTH + 1);

   logic [REQ_KEY_BITS-1:0] key_mask;
   cmd_type                 cmd_dec;
   cmd_type                 slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0]           fill_ff, fill_in;
   logic                    push;

   // keys are kept to the configured key width
   assign key_mask = ~({REQ_KEY_BITS{1'b1}} << KW);

   // classify the request code
   always_comb begin
      cmd_dec.op        = OP_NOP;
      cmd_dec.kind      = KIND_VAR;
      cmd_dec.miss_flag = 1'b0;
      cmd_dec.key       = req_data.key & key_mask;
      case (req_data.req_type)
         RQ_BIND_VAR: begin
            cmd_dec.op = OP_BIND;
         end
         RQ_BIND_TEMP: begin
            cmd_dec.op   = OP_BIND;
            cmd_dec.kind = KIND_TEMP;
         end
         RQ_UNBIND_VAR: begin
            cmd_dec.op = OP_UNBIND;
         end
         RQ_UNBIND_TEMP: begin
            cmd_dec.op   = OP_UNBIND;
            cmd_dec.kind = KIND_TEMP;
         end
         RQ_LOOKUP: begin
            cmd_dec.op        = OP_FIND;
            cmd_dec.miss_flag = 1'b1;
         end
         RQ_HAS: begin
            cmd_dec.op = OP_FIND;
         end
         RQ_FRESH_TEMP: begin
            cmd_dec.op = OP_FRESH;
         end
         default: begin
            cmd_dec.op = OP_NOP;
         end
      endcase
   end

   // command queue handshake
   assign req_ready    = (fill_ff != FW'(QUEUE_DEPTH));
   assign push         = req_valid && req_ready;
   assign q_head.valid = (fill_ff != '0);
   assign q_head.cmd   = slot_ff[rd_ptr_ff];

   // pointer and fill count updates
   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      fill_in   = fill_ff + FW'(push) - FW'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd_dec;
      end
   end

endmodule

[rtl/core/sab_back.sv]
// back end: binding stack memory, free-register search, lookups and result register
// depends on sab_pkg
module sab_back import sab_pkg::*; #(
   parameter int STACK_DEPTH = 32,
   parameter int KEY_BITS    = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type q_head,
   output logic           q_pop,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_beat_type   rsp_data,
   output back_stat_type  bk_stat
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int KW = (KEY_BITS < REQ_KEY_BITS) ? KEY_BITS : REQ_KEY_BITS;
   localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

   back_state_type       state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [TEMP_BITS-1:0] temp_ff, temp_in;
   logic [STACK_DEPTH:0] used_ff, used_in;
   logic [CW-1:0]        cursor_ff, cursor_in;
   logic                 chk_ff, chk_in;
   cmd_type              cmd_ff, cmd_in;
   rsp_beat_type         res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_beat_type         rsp_data_ff, rsp_data_in;

   // binding stack memory
   logic                 mem_kind [STACK_DEPTH];
   logic [KW-1:0]        mem_key  [STACK_DEPTH];
   logic [CW-1:0]        mem_reg  [STACK_DEPTH];
   logic                 rd_kind_ff;
   logic [KW-1:0]        rd_key_ff;
   logic [CW-1:0]        rd_reg_ff;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;

   cmd_type              head;
   logic                 stack_full, stack_empty;
   logic [CW-1:0]        count_dec, scan_dec;
   logic                 slot_free, rd_hit, scan_end, out_free;

   // shared conditions
   assign head        = q_head.cmd;
   assign stack_full  = (count_ff == DEPTH_C);
   assign stack_empty = (count_ff == '0);
   assign count_dec   = count_ff - CW'(1);
   assign scan_dec    = cursor_ff - CW'(1);
   assign slot_free   = !used_ff[cursor_ff];
   assign rd_hit      = chk_ff && (rd_kind_ff == KIND_VAR) && (rd_key_ff == cmd_ff.key[KW-1:0]);
   assign scan_end    = !chk_ff && (cursor_ff == '0);
   assign out_free    = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_head.valid) begin
               case (head.op)
                  OP_BIND:   state_in = stack_full  ? BK_DONE : BK_ALLOC;
                  OP_UNBIND: state_in = stack_empty ? BK_DONE : BK_POP_CHK;
                  OP_FIND:   state_in = BK_FIND;
                  default:   state_in = BK_DONE;
               endcase
            end
         end
         BK_ALLOC: begin
            if (slot_free) state_in = BK_DONE;
         end
         BK_POP_CHK: begin
            state_in = BK_DONE;
         end
         BK_FIND: begin
            if (rd_hit || scan_end) state_in = BK_DONE;
         end
         BK_DONE: begin
            if (out_free) state_in = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      q_pop        = 1'b0;
      count_in     = count_ff;
      temp_in      = temp_ff;
      used_in      = used_ff;
      cursor_in    = cursor_ff;
      chk_in       = 1'b0;
      cmd_in       = cmd_ff;
      res_in       = res_ff;
      rd_addr      = count_dec[AW-1:0];
      wr_en        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_head.valid) begin
               q_pop              = 1'b1;
               cmd_in             = head;
               res_in.reg_index   = '0;
               res_in.found       = 1'b0;
               res_in.temp_number = '0;
               res_in.status      = ST_OK;
               case (head.op)
                  OP_BIND: begin
                     cursor_in = '0;
                     if (stack_full) res_in.status = ST_FULL;
                  end
                  OP_UNBIND: begin
                     // top entry read issued here, checked next cycle
                     if (stack_empty) res_in.status = ST_EMPTY;
                  end
                  OP_FIND: begin
                     cursor_in = count_ff;
                  end
                  OP_FRESH: begin
                     res_in.temp_number = temp_ff;
                     temp_in            = temp_ff + TEMP_BITS'(1);
                  end
                  default: begin
                     res_in.status = ST_OK;
                  end
               endcase
            end
         end
         BK_ALLOC: begin
            // walk register indexes upward until one is free
            if (slot_free) begin
               wr_en              = 1'b1;
               used_in[cursor_ff] = 1'b1;
               count_in           = count_ff + CW'(1);
               res_in.reg_index   = RSP_REG_BITS'(cursor_ff);
            end else begin
               cursor_in = cursor_ff + CW'(1);
            end
         end
         BK_POP_CHK: begin
            if (rd_kind_ff != cmd_ff.kind) begin
               res_in.status = ST_WRONG_KIND;
            end else if (rd_key_ff != cmd_ff.key[KW-1:0]) begin
               res_in.status = ST_KEY_MISMATCH;
            end else begin
               res_in.reg_index   = RSP_REG_BITS'(rd_reg_ff);
               used_in[rd_reg_ff] = 1'b0;
               count_in           = count_dec;
            end
         end
         BK_FIND: begin
            // issue one read per cycle from the top down, check the previous one
            rd_addr = scan_dec[AW-1:0];
            if (cursor_ff != '0) begin
               cursor_in = scan_dec;
               chk_in    = 1'b1;
            end
            if (rd_hit) begin
               res_in.found     = 1'b1;
               res_in.reg_index = RSP_REG_BITS'(rd_reg_ff);
            end else if (scan_end && cmd_ff.miss_flag) begin
               res_in.status = ST_UNBOUND;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: begin
            chk_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         temp_ff      <= '0;
         used_ff      <= '0;
         cursor_ff    <= '0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         temp_ff      <= temp_in;
         used_ff      <= used_in;
         cursor_ff    <= cursor_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // stack memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_kind[count_ff[AW-1:0]] <= cmd_ff.kind;
         mem_key[count_ff[AW-1:0]]  <= cmd_ff.key[KW-1:0];
         mem_reg[count_ff[AW-1:0]]  <= cursor_ff;
      end
      rd_kind_ff <= mem_kind[rd_addr];
      rd_key_ff  <= mem_key[rd_addr];
      rd_reg_ff  <= mem_reg[rd_addr];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_data_ff;
   assign bk_stat.busy       = (state_ff != BK_IDLE);
   assign bk_stat.stack_full = stack_full;

endmodule
